/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the triangulator.
// Depends on nothing; take in with `include after the module header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that a condition never occurs, off while reset is high
`define ASSERT_NEVER_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

/* hw/rtl/tpt_pkg.sv */
// Constants and item types for the thick polyline triangulator.
// No dependencies.
package tpt_pkg;

   localparam int COORD_BITS = 24;
   localparam int THICK_BITS = 16;
   localparam logic [THICK_BITS-1:0] THICK_RESET = 16'd768;
   // magnitude of a coordinate difference
   localparam int ABS_BITS = COORD_BITS + 1;
   // difference width after scaling below 2^30
   localparam int A_BITS = (ABS_BITS > 30) ? 30 : ABS_BITS;
   localparam int S_BITS = 2 * A_BITS + 1;
   localparam int MAG_BITS = 15;
   // datapath width for squares, remainder and root terms
   localparam int X_BITS = 2 * A_BITS + 34;
   localparam int MPLIER_BITS = A_BITS + THICK_BITS;
   localparam int CNT_BITS = $clog2(MPLIER_BITS + 1);
   localparam int VSUM_BITS = ((COORD_BITS > MAG_BITS + 2) ? COORD_BITS : MAG_BITS + 2) + 1;
   localparam int VERTS = 6;

   typedef struct packed {
      logic                          starts_polyline;
      logic signed [COORD_BITS-1:0]  point_x;
      logic signed [COORD_BITS-1:0]  point_y;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  vertex_x;
      logic signed [COORD_BITS-1:0]  vertex_y;
      logic                          segment_done;
   } rsp_item_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SCALE = 8'b0000_0010,
      ST_SQX   = 8'b0000_0100,
      ST_SQY   = 8'b0000_1000,
      ST_AT    = 8'b0001_0000,
      ST_ATSQ  = 8'b0010_0000,
      ST_ROOT  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

endpackage

/* hw/rtl/thick_polyline_triangulator.sv */
// Thick polyline triangulator: widens each segment into two triangles.
// Depends on tpt_pkg and assert_macros.svh.
//
//   channel  direction  ports                          payload
//   req      in         req_valid, req_stall           tpt_pkg::req_item_type
//   rsp      out        rsp_valid, rsp_stall           tpt_pkg::rsp_item_type
//   csr      in         csr_write_en, csr_write_data   line thickness, 16 bits
//
// A point that opens a polyline, or repeats the previous point, produces no vertices.
// A segment runs through pre-scaling, the squares, (a*T)^2 and the root: the serial
// shift-add multiplier forms dx^2+dy^2 and (a*T)^2 one bit a cycle, and the offset
// root yields one bit a cycle; (a*T)^2 and the root run twice per segment.
// Differences wider than A_BITS are first halved until they fit. Six vertices then leave at
// one per cycle; rsp_stall holds them, and the next item can be taken while the last waits.
// Reset is synchronous and clears the previous point and the thickness to 768.
module thick_polyline_triangulator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tpt_pkg::req_item_type     req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tpt_pkg::rsp_item_type     rsp_item,
   input  logic                      csr_write_en,
   input  logic [tpt_pkg::THICK_BITS-1:0] csr_write_data
);

   localparam int CB = tpt_pkg::COORD_BITS;
   localparam int AB = tpt_pkg::ABS_BITS;
   localparam int AW = tpt_pkg::A_BITS;
   localparam int XW = tpt_pkg::X_BITS;
   localparam int MW = tpt_pkg::MPLIER_BITS;
   localparam int NW = tpt_pkg::CNT_BITS;
   localparam int SW = tpt_pkg::S_BITS;
   localparam int QW = tpt_pkg::MAG_BITS;
   localparam int VW = tpt_pkg::VSUM_BITS;
   localparam logic signed [VW-1:0] V_MAX = {{(VW-CB+1){1'b0}}, {(CB-1){1'b1}}};
   localparam logic signed [VW-1:0] V_MIN = {{(VW-CB+1){1'b1}}, {(CB-1){1'b0}}};

   tpt_pkg::state_type state_ff, state_in;

   logic [tpt_pkg::THICK_BITS-1:0] thick_ff, thick_in;
   logic signed [CB-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CB-1:0] p1_x_ff, p1_x_in, p1_y_ff, p1_y_in;
   logic have_prev_ff, have_prev_in;
   logic dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in;
   logic [AB-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [XW-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [MW-1:0] mplier_ff, mplier_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] s_ff, s_in;
   logic [XW-1:0] r_ff, r_in, e_ff, e_in, d2_ff, d2_in;
   logic [QW-1:0] q_ff, q_in, mx_ff, mx_in, my_ff, my_in;
   logic pass_ff, pass_in;
   logic [2:0] vcnt_ff, vcnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   tpt_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic req_take, first_pt;
   logic signed [CB:0] dx, dy;
   logic [XW-1:0] acc_step, delta;
   logic last, take, load_out;
   logic [QW-1:0] q_next;
   logic [AW-1:0] ax_s, ay_s;
   logic use_p2, neg;
   logic signed [CB-1:0] base_x, base_y;
   logic signed [VW-1:0] off_x, off_y, sum_x, sum_y, sat_x, sat_y;

   assign req_stall = (state_ff != tpt_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign first_pt  = req_item.starts_polyline || !have_prev_ff;
   assign dx = {req_item.point_x[CB-1], req_item.point_x} - {prev_x_ff[CB-1], prev_x_ff};
   assign dy = {req_item.point_y[CB-1], req_item.point_y} - {prev_y_ff[CB-1], prev_y_ff};

   assign ax_s = ax_ff[AW-1:0];
   assign ay_s = ay_ff[AW-1:0];
   assign acc_step = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
   assign last = (cnt_ff == NW'(1));
   assign delta = e_ff + d2_ff;
   assign take = (delta <= r_ff);
   assign q_next = {q_ff[QW-2:0], take};

   // vertex order: p1+o, p1-o, p2+o, p2+o, p1-o, p2-o
   assign use_p2 = (vcnt_ff == 3'd2) || (vcnt_ff == 3'd3) || (vcnt_ff == 3'd5);
   assign neg    = (vcnt_ff == 3'd1) || (vcnt_ff == 3'd4) || (vcnt_ff == 3'd5);
   assign base_x = use_p2 ? prev_x_ff : p1_x_ff;
   assign base_y = use_p2 ? prev_y_ff : p1_y_ff;
   assign off_x = (dy_neg_ff ^ neg) ? -$signed(VW'(mx_ff)) : $signed(VW'(mx_ff));
   assign off_y = (dx_neg_ff ^ neg) ? $signed(VW'(my_ff)) : -$signed(VW'(my_ff));
   assign sum_x = VW'(base_x) + off_x;
   assign sum_y = VW'(base_y) + off_y;
   assign sat_x = (sum_x > V_MAX) ? V_MAX : ((sum_x < V_MIN) ? V_MIN : sum_x);
   assign sat_y = (sum_y > V_MAX) ? V_MAX : ((sum_y < V_MIN) ? V_MIN : sum_y);
   assign load_out = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      thick_in     = csr_write_en ? csr_write_data : thick_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      p1_x_in      = p1_x_ff;
      p1_y_in      = p1_y_ff;
      have_prev_in = have_prev_ff;
      dx_neg_in    = dx_neg_ff;
      dy_neg_in    = dy_neg_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      e_in         = e_ff;
      d2_in        = d2_ff;
      q_in         = q_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      pass_in      = pass_ff;
      vcnt_in      = vcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      unique case (state_ff)
         tpt_pkg::ST_IDLE: begin
            if (req_take) begin
               prev_x_in    = req_item.point_x;
               prev_y_in    = req_item.point_y;
               p1_x_in      = prev_x_ff;
               p1_y_in      = prev_y_ff;
               have_prev_in = 1'b1;
               dx_neg_in    = dx[CB];
               dy_neg_in    = dy[CB];
               ax_in        = dx[CB] ? AB'(-dx) : AB'(dx);
               ay_in        = dy[CB] ? AB'(-dy) : AB'(dy);
               if (!first_pt && (dx != '0 || dy != '0)) begin
                  state_in = tpt_pkg::ST_SCALE;
               end
            end
         end
         tpt_pkg::ST_SCALE: begin
            // halve both until they fit the root datapath
            if ((ax_ff >> AW) != '0 || (ay_ff >> AW) != '0) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end else begin
               acc_in    = '0;
               mcand_in  = XW'(ax_s);
               mplier_in = MW'(ax_s);
               cnt_in    = NW'(AW);
               state_in  = tpt_pkg::ST_SQX;
            end
         end
         tpt_pkg::ST_SQX: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - NW'(1);
            if (last) begin
               mcand_in  = XW'(ay_s);
               mplier_in = MW'(ay_s);
               cnt_in    = NW'(AW);
               state_in  = tpt_pkg::ST_SQY;
            end
         end
         tpt_pkg::ST_SQY: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - NW'(1);
            if (last) begin
               s_in      = acc_step[SW-1:0];
               acc_in    = '0;
               mcand_in  = XW'(ay_s);
               mplier_in = MW'(thick_ff);
               cnt_in    = NW'(tpt_pkg::THICK_BITS);
               pass_in   = 1'b0;
               state_in  = tpt_pkg::ST_AT;
            end
         end
         tpt_pkg::ST_AT: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - NW'(1);
            if (last) begin
               acc_in    = '0;
               mcand_in  = acc_step;
               mplier_in = acc_step[MW-1:0];
               cnt_in    = NW'(MW);
               state_in  = tpt_pkg::ST_ATSQ;
            end
         end
         tpt_pkg::ST_ATSQ: begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - NW'(1);
            if (last) begin
               r_in     = acc_step;
               e_in     = '0;
               d2_in    = XW'(s_ff) << (2 * (QW - 1) + 2);
               q_in     = '0;
               cnt_in   = NW'(QW);
               state_in = tpt_pkg::ST_ROOT;
            end
         end
         tpt_pkg::ST_ROOT: begin
            // keep r = (aT)^2 - 4q^2 S, e = 4Sq << (b+1), d2 = 4S << 2b
            if (take) begin
               r_in = r_ff - delta;
               e_in = (e_ff + (d2_ff << 1)) >> 1;
            end else begin
               e_in = e_ff >> 1;
            end
            d2_in  = d2_ff >> 2;
            q_in   = q_next;
            cnt_in = cnt_ff - NW'(1);
            if (last) begin
               if (!pass_ff) begin
                  mx_in     = q_next;
                  pass_in   = 1'b1;
                  acc_in    = '0;
                  mcand_in  = XW'(ax_s);
                  mplier_in = MW'(thick_ff);
                  cnt_in    = NW'(tpt_pkg::THICK_BITS);
                  state_in  = tpt_pkg::ST_AT;
               end else begin
                  my_in    = q_next;
                  vcnt_in  = '0;
                  state_in = tpt_pkg::ST_EMIT;
               end
            end
         end
         tpt_pkg::ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.vertex_x     = sat_x[CB-1:0];
               rsp_item_in.vertex_y     = sat_y[CB-1:0];
               rsp_item_in.segment_done = (vcnt_ff == 3'(tpt_pkg::VERTS - 1));
               vcnt_in                  = vcnt_ff + 3'd1;
               if (vcnt_ff == 3'(tpt_pkg::VERTS - 1)) begin
                  state_in = tpt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = tpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpt_pkg::ST_IDLE;
         thick_ff     <= tpt_pkg::THICK_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
         vcnt_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         thick_ff     <= thick_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         vcnt_ff      <= vcnt_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_x_ff     <= p1_x_in;
      p1_y_ff     <= p1_y_in;
      dx_neg_ff   <= dx_neg_in;
      dy_neg_ff   <= dy_neg_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      s_ff        <= s_in;
      r_ff        <= r_in;
      e_ff        <= e_in;
      d2_ff       <= d2_in;
      q_ff        <= q_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`include "assert_macros.svh"

   `ASSERT_CLK(a_state_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `ASSERT_CLK(a_take_goes_idle_or_scale, clock, reset, req_take |=> (state_ff == tpt_pkg::ST_IDLE || state_ff == tpt_pkg::ST_SCALE), "accepted item did not start a segment")
   `ASSERT_NEVER_CLK(a_root_count_live, clock, reset, (state_ff == tpt_pkg::ST_ROOT) && (cnt_ff == '0), "root step count exhausted")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_item_ff)), "stalled vertex changed")

endmodule

/* bench/tpt_checker.sv */
// Checker for the thick polyline triangulator: predicts the vertices of each
// accepted point and compares them with the emitted vertex stream.
// Depends on tpt_pkg.
module tpt_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  tpt_pkg::req_item_type         req_item,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  tpt_pkg::rsp_item_type         rsp_item,
   input  logic                          csr_write_en,
   input  logic [tpt_pkg::THICK_BITS-1:0] csr_write_data,
   output int                            fail_count,
   output int                            pending_vertices,
   output int                            vertex_count
);
   timeunit 1ns;
   timeprecision 1ps;

   tpt_pkg::rsp_item_type vertex_queue[$];
   logic [15:0]        thickness;
   longint             last_x, last_y;
   bit                 have_last;

   assign pending_vertices = vertex_queue.size();

   // largest q with 4*q*q*s <= (a*t)^2, built one bit at a time
   function automatic longint offset_size(longint a, longint s, longint t);
      logic [127:0] rhs, lhs;
      longint q, c;
      rhs = 128'(a * t) * 128'(a * t);
      q = 0;
      for (int b = 14; b >= 0; b--) begin
         c = q | (longint'(1) << b);
         lhs = 128'(c * c) * 128'(4 * s);
         if (lhs <= rhs) q = c;
      end
      return q;
   endfunction

   function automatic logic signed [tpt_pkg::COORD_BITS-1:0] clamp(longint v);
      longint hi, lo;
      hi = (longint'(1) << (tpt_pkg::COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[tpt_pkg::COORD_BITS-1:0];
      if (v < lo) return lo[tpt_pkg::COORD_BITS-1:0];
      return v[tpt_pkg::COORD_BITS-1:0];
   endfunction

   task automatic push_vertex(longint x, longint y, bit last);
      tpt_pkg::rsp_item_type v;
      v.vertex_x = clamp(x);
      v.vertex_y = clamp(y);
      v.segment_done = last;
      vertex_queue.push_back(v);
   endtask

   task automatic predict_segment(tpt_pkg::req_item_type p);
      longint x, y, x1, y1, dx, dy, ax, ay, s, ox, oy;
      bit opens;
      x = p.point_x;
      y = p.point_y;
      x1 = last_x;
      y1 = last_y;
      opens = p.starts_polyline || !have_last;
      last_x = x;
      last_y = y;
      have_last = 1;
      dx = x - x1;
      dy = y - y1;
      if (opens || (dx == 0 && dy == 0)) return;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      while (ax >= (longint'(1) << 30) || ay >= (longint'(1) << 30)) begin
         ax >>= 1;
         ay >>= 1;
      end
      s = ax * ax + ay * ay;
      ox = offset_size(ay, s, thickness);
      oy = offset_size(ax, s, thickness);
      if (dy < 0) ox = -ox;
      if (dx >= 0) oy = -oy;
      push_vertex(x1 + ox, y1 + oy, 0);
      push_vertex(x1 - ox, y1 - oy, 0);
      push_vertex(x + ox, y + oy, 0);
      push_vertex(x + ox, y + oy, 0);
      push_vertex(x1 - ox, y1 - oy, 0);
      push_vertex(x - ox, y - oy, 1);
   endtask

   always @(posedge clock) begin
      tpt_pkg::rsp_item_type want;
      if (reset) begin
         thickness <= tpt_pkg::THICK_RESET;
         have_last = 0;
         last_x = 0;
         last_y = 0;
         vertex_queue.delete();
         fail_count <= 0;
         vertex_count <= 0;
      end else begin
         if (csr_write_en) thickness <= csr_write_data;
         if (req_valid && !req_stall) predict_segment(req_item);
         if (rsp_valid && !rsp_stall) begin
            vertex_count <= vertex_count + 1;
            if (vertex_queue.size() == 0) begin
               $display("%0t: unexpected vertex %p", $time, rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               want = vertex_queue.pop_front();
               if (rsp_item !== want) begin
                  $display("%0t: vertex mismatch expected %p actual %p",
                           $time, want, rsp_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* bench/tb.sv */
// Top of the triangulator bench: clock, reset, point stimulus and verdict.
// Depends on tpt_pkg, tpt_checker and thick_polyline_triangulator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   tpt_pkg::req_item_type req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   tpt_pkg::rsp_item_type rsp_item;
   logic                  csr_write_en;
   logic [tpt_pkg::THICK_BITS-1:0] csr_write_data;
   int                    fail_count, pending_vertices, vertex_count;
   int                    send_idle_pct, recv_idle_pct;
   int                    quiet_cycles;
   int                    points_sent;

   thick_polyline_triangulator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   tpt_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_vertices(pending_vertices),
      .vertex_count(vertex_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stall, redrawn each falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // watchdog: count cycles with no accepted item on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // valid stays up after acceptance until the next call or a drain drops it
   task automatic send_point(bit opens, longint x, longint y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_item.starts_polyline <= opens;
      req_item.point_x <= x[tpt_pkg::COORD_BITS-1:0];
      req_item.point_y <= y[tpt_pkg::COORD_BITS-1:0];
      do @(posedge clock); while (req_stall);
      points_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_vertices != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic set_thickness(logic [15:0] t);
      drain();
      csr_write_en <= 1;
      csr_write_data <= t;
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic random_points(int count);
      longint x, y, span;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) span = 24'h7fffff;
         else span = $urandom_range(1, 4096);
         x = $signed($urandom_range(2 * span)) - span;
         y = $signed($urandom_range(2 * span)) - span;
         if ($urandom_range(15) == 0) begin
            x = $signed(24'($urandom));
            y = $signed(24'($urandom));
         end
         send_point($urandom_range(7) == 0, x, y);
      end
   endtask

   initial begin
      longint maxc, minc;
      maxc = (longint'(1) << (tpt_pkg::COORD_BITS - 1)) - 1;
      minc = -(longint'(1) << (tpt_pkg::COORD_BITS - 1));
      reset = 1;
      req_valid = 0;
      req_item = '0;
      rsp_stall = 0;
      csr_write_en = 0;
      csr_write_data = '0;
      send_idle_pct = 9;
      recv_idle_pct = 58;
      points_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // first point after reset, without a start flag
      send_point(0, 256, 256);
      send_point(0, 1280, 256);
      send_point(0, 1280, 256);          // repeated point
      send_point(0, 1280, -2000);
      send_point(1, 0, 0);               // new polyline
      send_point(0, -300, 700);
      send_point(0, maxc, maxc);         // saturation
      send_point(0, minc, minc);
      send_point(0, maxc, minc);
      send_point(1, minc, 0);
      send_point(0, maxc, 0);
      send_point(0, maxc, -1);
      set_thickness(16'hffff);
      send_point(1, 100, 100);
      send_point(0, 101, 100);
      send_point(0, 101, 99);
      send_point(0, minc, maxc);
      set_thickness(16'h0000);
      send_point(0, 0, 0);
      send_point(0, 5, 7);
      set_thickness(16'd1);
      send_point(0, 77, -3);
      send_point(0, 4000, 4001);
      // wait out every vertex before continuing
      drain();

      set_thickness(16'd512);
      random_points(30);
      send_idle_pct = 58;
      recv_idle_pct = 9;
      set_thickness(16'($urandom));
      random_points(30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_thickness(16'd768);
      random_points(27);

      drain();
      $display("tb: %0d points sent, %0d vertices checked, thickness 0..65535",
               points_sent, vertex_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tpt_pkg.sv
hw/rtl/thick_polyline_triangulator.sv
bench/tpt_checker.sv
bench/tb.sv
